>>> rtl/rtt_fm_pkg.sv
// Package for the RTT flood mode controller.
// Holds the configuration struct, the result struct, event codes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package rtt_fm_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_MIN_PER   = 2'd1;
  localparam logic [1:0] CFG_MAX_PER   = 2'd2;
  localparam logic [1:0] CFG_REVIEW    = 2'd3;

  // Configuration reset values.
  localparam logic [15:0] THRESHOLD_RST = 16'd250;
  localparam logic [15:0] MIN_PER_RST   = 16'd1000;
  localparam logic [15:0] MAX_PER_RST   = 16'd60000;
  localparam logic [15:0] REVIEW_RST    = 16'd10000;

  // Flood period after reset.
  localparam logic [15:0] PERIOD_RST = 16'd10000;

  // Event codes reported with every result.
  localparam logic [2:0] EV_NONE         = 3'd0;
  localparam logic [2:0] EV_ENTER        = 3'd1;
  localparam logic [2:0] EV_ENTER_DOUBLE = 3'd2;
  localparam logic [2:0] EV_FELL         = 3'd3;
  localparam logic [2:0] EV_CLEAR        = 3'd4;
  localparam logic [2:0] EV_CLEAR_HALVE  = 3'd5;

  // Beat widths.
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  typedef struct packed {
    logic [15:0] threshold;
    logic [15:0] min_period;
    logic [15:0] max_period;
    logic [15:0] review_period;
  } cfg_t;

  typedef struct packed {
    logic        flooded;
    logic [15:0] period;
    logic [2:0]  ev;
  } res_t;

endpackage

>>> rtl/rtt_fm_smooth.sv
// Smoothed RTT update: moves the fixed point value a tenth of the way to the sample.
// The divide by ten is a reciprocal multiply. Depends on nothing but its parameter.
`timescale 1ns / 1ps

module rtt_fm_smooth #(
  parameter int FRACTION_BITS = 4
) (
  input  logic [16+FRACTION_BITS-1:0] old_i,
  input  logic [15:0]                 sample_i,
  output logic [16+FRACTION_BITS-1:0] nxt_o
);

  localparam int SW = 16 + FRACTION_BITS;
  localparam int XW = SW + 1;
  localparam int SH = XW + 3;
  // ceil(2^SH / 10); the error stays below one eighth of a unit, so floor is exact.
  localparam longint unsigned RECIP = ((64'd1 << SH) + 64'd9) / 64'd10;

  logic [XW-1:0]   recip_c;
  logic [SW-1:0]   target;
  logic            up;
  logic [SW-1:0]   mag;
  logic [XW-1:0]   rounded;
  logic [2*XW-1:0] prod;
  logic [SW-1:0]   step;

  assign recip_c = RECIP[XW-1:0];
  assign target  = SW'(sample_i) << FRACTION_BITS;
  assign up      = (target >= old_i);
  assign mag     = up ? (target - old_i) : (old_i - target);

  // Step is mag / 10 rounded to nearest, ties away from zero.
  assign rounded = {1'b0, mag} + XW'(5);
  assign prod    = (2*XW)'(rounded) * (2*XW)'(recip_c);
  assign step    = SW'(prod[2*XW-1:SH]);

  // A zero value means no history, so the sample is taken as is.
  always_comb begin
    if (old_i == '0) begin
      nxt_o = target;
    end else if (up) begin
      nxt_o = old_i + step;
    end else begin
      nxt_o = old_i - step;
    end
  end

endmodule

>>> rtl/rtt_fm_ctrl.sv
// Flood mode state: smoothed RTT, flood flag, adaptive period, exit and review times.
// Depends on rtt_fm_pkg and rtt_fm_smooth.
`timescale 1ns / 1ps

module rtt_fm_ctrl #(
  parameter int FRACTION_BITS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        upd_i,
  input  rtt_fm_pkg::cfg_t            cfg_i,
  input  logic [31:0]                 now_i,
  input  logic [15:0]                 sample_i,
  output logic [15:0]                 smoothed_o,
  output rtt_fm_pkg::res_t            res_o
);

  import rtt_fm_pkg::*;

  localparam int SW = 16 + FRACTION_BITS;

  logic [SW-1:0] smoothed_q, smoothed_d;
  logic          flag_q, flag_d;
  logic [15:0]   period_q, period_d;
  logic [31:0]   exit_q, exit_d;
  logic [31:0]   review_q, review_d;

  logic [SW-1:0] thr_fx;
  logic [31:0]   since_exit;
  logic [31:0]   since_review;
  logic [16:0]   dbl;
  logic [15:0]   half;
  logic [2:0]    ev;

  rtt_fm_smooth #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_smooth (
    .old_i   (smoothed_q),
    .sample_i(sample_i),
    .nxt_o   (smoothed_d)
  );

  assign thr_fx       = SW'(cfg_i.threshold) << FRACTION_BITS;
  assign since_exit   = now_i - exit_q;
  assign since_review = now_i - review_q;
  assign dbl          = {period_q, 1'b0};
  assign half         = period_q >> 1;

  // Threshold crossings and the clearing check, in priority order.
  always_comb begin
    flag_d   = flag_q;
    period_d = period_q;
    exit_d   = exit_q;
    review_d = review_q;
    ev       = EV_NONE;
    if (smoothed_q < thr_fx && smoothed_d > thr_fx) begin
      flag_d = 1'b1;
      ev     = EV_ENTER;
      if (since_exit < {16'd0, period_q}) begin
        period_d = (dbl < {1'b0, cfg_i.max_period}) ? dbl[15:0] : cfg_i.max_period;
        ev       = EV_ENTER_DOUBLE;
      end
    end else if (smoothed_q > thr_fx && smoothed_d < thr_fx) begin
      exit_d   = now_i;
      review_d = now_i;
      ev       = EV_FELL;
    end else if (smoothed_d < thr_fx && since_exit > {16'd0, period_q}) begin
      flag_d = 1'b0;
      ev     = EV_CLEAR;
      if (since_review > {16'd0, cfg_i.review_period}) begin
        review_d = now_i;
        period_d = (half > cfg_i.min_period) ? half : cfg_i.min_period;
        ev       = EV_CLEAR_HALVE;
      end
    end
  end

  assign smoothed_o    = smoothed_d[SW-1:FRACTION_BITS];
  assign res_o.flooded = flag_d;
  assign res_o.period  = period_d;
  assign res_o.ev      = ev;

  // State moves only when a beat is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smoothed_q <= '0;
      flag_q     <= 1'b0;
      period_q   <= PERIOD_RST;
      exit_q     <= '0;
      review_q   <= '0;
    end else if (upd_i) begin
      smoothed_q <= smoothed_d;
      flag_q     <= flag_d;
      period_q   <= period_d;
      exit_q     <= exit_d;
      review_q   <= review_d;
    end
  end

endmodule

>>> rtl/rtt_flood_mode_control_core.sv
// Top level of the RTT flood mode controller: stream ports, config registers, pipeline.
// Depends on rtt_fm_pkg and rtt_fm_ctrl.
// Datapath: an input beat is taken into the input register and its result into the output
// register; the result moves on only when the output register is free or being drained.
// Throughput: one beat per cycle while the output register is free or drained; the
// smoothing multiply and threshold logic sit between the input and output registers.
// Reset: asynchronous, active low; clears the state and loads the config defaults.
`timescale 1ns / 1ps

module rtt_flood_mode_control_core #(
  parameter int FRACTION_BITS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [15:0]                       cfg_data_i,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] now_ms, [47:32] rtt_sample_ms
  input  logic [rtt_fm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Output stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] flooded, [16:1] smoothed_rtt_ms, [32:17] flood_period_ms, [35:33] event_res,
  // [39:36] zero
  output logic [rtt_fm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  import rtt_fm_pkg::*;

  cfg_t        cfg_q;
  logic        in_valid_q;
  logic [31:0] in_now_q;
  logic [15:0] in_rtt_q;
  logic        out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic        adv;
  logic [15:0] smoothed;
  res_t        res;

  // The held beat moves on when the output register is free or being drained.
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold     <= THRESHOLD_RST;
      cfg_q.min_period    <= MIN_PER_RST;
      cfg_q.max_period    <= MAX_PER_RST;
      cfg_q.review_period <= REVIEW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD: cfg_q.threshold     <= cfg_data_i;
        CFG_MIN_PER:   cfg_q.min_period    <= cfg_data_i;
        CFG_MAX_PER:   cfg_q.max_period    <= cfg_data_i;
        CFG_REVIEW:    cfg_q.review_period <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_now_q <= s_axis_tdata[31:0];
      in_rtt_q <= s_axis_tdata[47:32];
    end
  end

  rtt_fm_ctrl #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (adv),
    .cfg_i     (cfg_q),
    .now_i     (in_now_q),
    .sample_i  (in_rtt_q),
    .smoothed_o(smoothed),
    .res_o     (res)
  );

  assign out_data_d = {4'd0, res.ev, res.period, smoothed, res.flooded};

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
